// ----- rtl/tss_pkg.sv -----
`default_nettype none
package tss_pkg;

  typedef struct packed {
    logic [7:0]  slot_index;
    logic        candidate_valid;
    logic [31:0] metric;
    logic        is_peer;
    logic        over_maxload;
    logic [31:0] last_seen_ms;
    logic [31:0] blacklist_until_ms;
    logic [31:0] now_ms;
    logic        write_scan;
    logic [31:0] path_hash;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] winner_slot;
  } out_item_t;

  localparam logic [1:0] REG_ALLOW_BLACK = 2'd0;
  localparam logic [1:0] REG_STALE_AFTER = 2'd1;
  localparam logic [1:0] REG_FUZZ        = 2'd2;
  localparam logic [1:0] REG_AFFINITY    = 2'd3;

  localparam int TIER_FRESH = 0;
  localparam int TIER_STALE = 1;
  localparam int TIER_OVER  = 2;
  localparam int TIER_PEER  = 3;
  localparam int TIER_BLACK = 4;
  localparam int TIER_COUNT = 5;

  localparam logic [6:0] FUZZ_MAX = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_AFF_RD,
    ST_AFF_WAIT,
    ST_BOUND,
    ST_BAND_RD,
    ST_BAND_CHK,
    ST_ROT_MOD,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/tiered_server_selector.sv -----
`default_nettype none
// Tiered server selector. Each candidate transfer is first registered, and
// the input stalls while it is held. It is then classified and folded into
// five per-tier best registers, and a fresh candidate is appended, while the
// list has room, to a list memory that holds slot and metric. The input stalls
// for the whole pick that follows a transfer marked last.
// Affinity runs a serial modulo of path_hash by the fresh count, then one list
// read (ST_AFF_RD) and a wait state (ST_AFF_WAIT). Fuzz computes the band
// product in ST_BOUND and walks the list, one read and one check state per
// entry, to count the band. It then runs a serial modulo of the rotation
// counter, and walks the list again the same way up to the chosen member. The
// single list memory port and the serial divider keep these steps serial.
// A final state, ST_OUT, loads the result into the output register. The pick
// holds in that state only while an earlier result is still waiting there.
module tiered_server_selector #(
  parameter int SLOTS     = 256,
  parameter int FRESH_MAX = 64
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic cfg_we,
  input  wire                logic [1:0] cfg_index,
  input  wire                logic [30:0] cfg_data,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  wire tss_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire                logic out_stall,
  output tss_pkg::out_item_t out_data
);

  localparam int AW = (FRESH_MAX > 1) ? $clog2(FRESH_MAX) : 1;
  localparam int CW = $clog2(FRESH_MAX + 1);

  function automatic logic [7:0] FUZZ_SUB(input logic [6:0] f);
    logic [6:0] c;
    c = (f > tss_pkg::FUZZ_MAX) ? tss_pkg::FUZZ_MAX : f;
    return {1'b0, tss_pkg::FUZZ_MAX} - {1'b0, c};
  endfunction

  function automatic logic [7:0] FUZZ_ADD(input logic [6:0] f);
    logic [6:0] c;
    c = (f > tss_pkg::FUZZ_MAX) ? tss_pkg::FUZZ_MAX : f;
    return {1'b0, tss_pkg::FUZZ_MAX} + {1'b0, c};
  endfunction

  // Configuration registers.
  logic        allow_black;
  logic [30:0] stale_after;
  logic [6:0]  fuzz_pct;
  logic        affinity_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_black <= 1'b0;
      stale_after <= '0;
      fuzz_pct    <= '0;
      affinity_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tss_pkg::REG_ALLOW_BLACK: allow_black <= cfg_data[0];
        tss_pkg::REG_STALE_AFTER: stale_after <= cfg_data;
        tss_pkg::REG_FUZZ:        fuzz_pct    <= cfg_data[6:0];
        tss_pkg::REG_AFFINITY:    affinity_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Fresh list memory.
  logic [39:0] list_mem [FRESH_MAX];
  logic        list_we;
  logic [AW-1:0] list_waddr, list_raddr;
  logic [39:0] list_wdata, list_rdata;

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_rdata <= list_mem[list_raddr];
  end

  // Scan state.
  tss_pkg::state_t state, state_next;
  logic            item_v;
  tss_pkg::in_item_t item;
  logic [4:0]      tier_valid;
  logic [7:0]      tier_slot [tss_pkg::TIER_COUNT];
  logic [31:0]     tier_metric [tss_pkg::TIER_COUNT];
  logic [CW-1:0]   fresh_count;
  logic [CW-1:0]   fresh_count_next;
  logic [31:0]     rotate_counter;

  // Pick datapath registers.
  logic            pick_wr;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   nb;
  logic [CW-1:0]   sel_cnt;
  logic [39:0]     bound;
  logic [31:0]     div_num;
  logic [CW-1:0]   div_den;
  logic [CW-1:0]   rem;
  logic [5:0]      div_cnt;
  logic            found_r;
  logic [7:0]      win_r;
  logic            out_free;

  assign in_stall = (state != tss_pkg::ST_IDLE) || item_v;
  assign out_free = !out_valid || !out_stall;

  // Classification of the registered item.
  logic        cand_ok, banned, aged_out;
  logic [31:0] age;
  logic [4:0]  offer;
  always_comb begin
    age      = item.now_ms - item.last_seen_ms;
    cand_ok  = item.candidate_valid && ({24'd0, item.slot_index} < 32'(SLOTS));
    banned   = (item.blacklist_until_ms != 32'd0) &&
               (item.blacklist_until_ms > item.now_ms);
    aged_out = (stale_after != 31'd0) && !age[31] && (age[30:0] > stale_after);
    offer    = '0;
    if (cand_ok) begin
      priority if (banned) offer[tss_pkg::TIER_BLACK] = allow_black;
      else if (item.is_peer) offer[tss_pkg::TIER_PEER] = 1'b1;
      else if (item.over_maxload) offer[tss_pkg::TIER_OVER] = 1'b1;
      else begin
        offer[tss_pkg::TIER_STALE] = 1'b1;
        offer[tss_pkg::TIER_FRESH] = !aged_out;
      end
    end
  end

  logic [4:0] better;
  always_comb begin
    for (int t = 0; t < tss_pkg::TIER_COUNT; t++) begin
      better[t] = offer[t] && (!tier_valid[t] ||
                  (item.write_scan ? (item.metric > tier_metric[t])
                                   : (item.metric < tier_metric[t])));
    end
  end

  // Best non-empty tier once the current item is folded in.
  logic       pick_found;
  logic [7:0] pick_win;
  always_comb begin
    pick_found = 1'b0;
    pick_win   = 8'd0;
    for (int t = tss_pkg::TIER_COUNT - 1; t >= 0; t--) begin
      if (tier_valid[t] || better[t]) begin
        pick_found = 1'b1;
        pick_win   = better[t] ? item.slot_index : tier_slot[t];
      end
    end
  end

  // Band membership of the entry just read. The bound register holds
  // best * (100 -/+ fuzz), so the metric is scaled by 100 instead of dividing.
  logic [39:0] metric_x100;
  logic        in_band;
  always_comb begin
    metric_x100 = {2'd0, list_rdata[31:0], 6'd0} + {3'd0, list_rdata[31:0], 5'd0} +
                  {6'd0, list_rdata[31:0], 2'd0};
    in_band = pick_wr ? ((metric_x100 + 40'd100) > bound)
                      : (metric_x100 <= bound);
  end

  assign fresh_count_next = list_we ? fresh_count + CW'(1) : fresh_count;

  logic fuzz_go;
  assign fuzz_go = (fuzz_pct != 7'd0) && (fresh_count_next >= CW'(2)) &&
                   (tier_valid[tss_pkg::TIER_FRESH] || better[tss_pkg::TIER_FRESH]);

  // Serial restoring divider step.
  logic [CW:0] rem_sh;
  assign rem_sh = {rem, div_num[31]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tss_pkg::ST_IDLE:
        if (item_v && item.last) begin
          if (affinity_on && fresh_count_next > CW'(1)) state_next = tss_pkg::ST_MOD;
          else if (fuzz_go) state_next = tss_pkg::ST_BOUND;
          else state_next = tss_pkg::ST_OUT;
        end
      tss_pkg::ST_MOD:
        if (div_cnt == 6'd31) state_next = tss_pkg::ST_AFF_RD;
      tss_pkg::ST_AFF_RD:   state_next = tss_pkg::ST_AFF_WAIT;
      tss_pkg::ST_AFF_WAIT: state_next = tss_pkg::ST_OUT;
      tss_pkg::ST_BOUND:    state_next = tss_pkg::ST_BAND_RD;
      tss_pkg::ST_BAND_RD:  state_next = tss_pkg::ST_BAND_CHK;
      tss_pkg::ST_BAND_CHK:
        if (idx + CW'(1) >= fresh_count) state_next = tss_pkg::ST_ROT_MOD;
        else state_next = tss_pkg::ST_BAND_RD;
      tss_pkg::ST_ROT_MOD:
        if (nb < CW'(2)) state_next = tss_pkg::ST_OUT;
        else if (div_cnt == 6'd32) state_next = tss_pkg::ST_SEL_RD;
      tss_pkg::ST_SEL_RD:   state_next = tss_pkg::ST_SEL_CHK;
      tss_pkg::ST_SEL_CHK:
        if (in_band && sel_cnt == rem) state_next = tss_pkg::ST_OUT;
        else state_next = tss_pkg::ST_SEL_RD;
      tss_pkg::ST_OUT:
        if (out_free) state_next = tss_pkg::ST_IDLE;
      default:              state_next = tss_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    list_we    = (state == tss_pkg::ST_IDLE) && item_v && offer[0] &&
                 (fresh_count < CW'(FRESH_MAX));
    list_waddr = fresh_count[AW-1:0];
    list_wdata = {item.slot_index, item.metric};
    list_raddr = (state == tss_pkg::ST_AFF_RD) ? rem[AW-1:0] : idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tss_pkg::ST_IDLE;
      item_v     <= 1'b0;
      tier_valid <= '0;
      fresh_count <= '0;
      rotate_counter <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tss_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_valid && !in_stall) item_v <= 1'b1;
      else if (state == tss_pkg::ST_IDLE) item_v <= 1'b0;

      unique case (state)
        tss_pkg::ST_IDLE:
          if (item_v) begin
            for (int t = 0; t < tss_pkg::TIER_COUNT; t++) begin
              if (better[t]) tier_valid[t] <= 1'b1;
            end
            fresh_count <= fresh_count_next;
          end
        tss_pkg::ST_ROT_MOD:
          if (nb >= CW'(2) && div_cnt == 6'd32) rotate_counter <= rotate_counter + 32'd1;
        tss_pkg::ST_OUT: begin
          tier_valid  <= '0;
          fresh_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item <= in_data;
    unique case (state)
      tss_pkg::ST_IDLE:
        if (item_v) begin
          for (int t = 0; t < tss_pkg::TIER_COUNT; t++) begin
            if (better[t]) begin
              tier_slot[t]   <= item.slot_index;
              tier_metric[t] <= item.metric;
            end
          end
          pick_wr    <= item.write_scan;
          div_num    <= item.path_hash;
          div_den    <= fresh_count_next;
          rem        <= '0;
          div_cnt    <= '0;
          idx        <= '0;
          nb         <= '0;
          sel_cnt    <= '0;
          found_r    <= pick_found;
          win_r      <= pick_win;
        end
      tss_pkg::ST_MOD: begin
        if (rem_sh >= {1'b0, div_den}) rem <= CW'(rem_sh - {1'b0, div_den});
        else rem <= rem_sh[CW-1:0];
        div_num <= {div_num[30:0], 1'b0};
        div_cnt <= div_cnt + 6'd1;
      end
      tss_pkg::ST_AFF_WAIT: begin
        found_r <= 1'b1;
        win_r   <= list_rdata[39:32];
      end
      tss_pkg::ST_BOUND: begin
        // Band product: best fresh metric times (100 -/+ fuzz).
        bound <= 40'(tier_metric[0]) * (pick_wr
                 ? 40'(FUZZ_SUB(fuzz_pct)) : 40'(FUZZ_ADD(fuzz_pct)));
      end
      tss_pkg::ST_BAND_CHK: begin
        if (in_band) nb <= nb + CW'(1);
        idx <= idx + CW'(1);
        if (idx + CW'(1) >= fresh_count) begin
          div_num <= rotate_counter;
          rem     <= '0;
          div_cnt <= '0;
          div_den <= in_band ? nb + CW'(1) : nb;
        end
      end
      tss_pkg::ST_ROT_MOD: begin
        if (div_cnt != 6'd32) begin
          if (rem_sh >= {1'b0, div_den}) rem <= CW'(rem_sh - {1'b0, div_den});
          else rem <= rem_sh[CW-1:0];
          div_num <= {div_num[30:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
        end
        idx <= '0;
      end
      tss_pkg::ST_SEL_CHK: begin
        idx <= idx + CW'(1);
        if (in_band) begin
          sel_cnt <= sel_cnt + CW'(1);
          if (sel_cnt == rem) win_r <= list_rdata[39:32];
        end
      end
      tss_pkg::ST_OUT:
        if (out_free) begin
          out_data.found       <= found_r;
          out_data.winner_slot <= found_r ? win_r : 8'd0;
        end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
